// ----- design/tvn_pkg.sv -----
// package: payload types and hash constants for the tiling value noise texel generator
package tvn_pkg;

    typedef struct packed {
        logic [7:0] texel_x;
        logic [7:0] texel_y;
    } texel_in_t;

    typedef struct packed {
        logic [7:0] coverage_byte;
        logic [7:0] type_byte;
    } texel_out_t;

    // map edge in texels, a power of two from 16 to 4096
    localparam int          MAP_SIZE     = 256;

    localparam logic [31:0] HASH_MUL_X   = 32'h8da6b343;
    localparam logic [31:0] HASH_MUL_Y   = 32'hd8163841;
    localparam logic [31:0] HASH_MUL_MIX = 32'h9e3779b1;
    localparam logic [31:0] SEED_XOR_P8  = 32'h00000077;
    localparam logic [31:0] SEED_XOR_P3  = 32'h0000abcd;
    localparam logic [16:0] WEIGHT_P4    = 17'd42598;
    localparam logic [16:0] WEIGHT_P8    = 17'd22938;

endpackage

// ----- design/tiling_value_noise_texel_gen.sv -----
// top level: pipelined tiling value noise texel generator
//
//  channel | direction | handshake                 | payload
//  in      | in        | in_valid / in_stall       | texel_in_t (texel_x, texel_y)
//  out     | out       | out_valid / out_stall     | texel_out_t (coverage_byte, type_byte)
//  cfg     | in        | cfg_we / cfg_wdata        | noise_seed
//
// one word enters per cycle while in_stall is low; it then passes through the registered
// stages in order, and out_valid rises once the word reaches the byte conversion stage.
// the stage count is set by the hash multiplies and the two blend levels.
// reset clears all valid bits and sets the seed to zero.
// a stall on out holds each stage that carries a word while every later stage carries one; empty stages still fill.
module tiling_value_noise_texel_gen (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tvn_pkg::texel_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tvn_pkg::texel_out_t out_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);
    import tvn_pkg::*;

    localparam int SHIFT = $clog2(MAP_SIZE);
    localparam int NST   = 7;

    // per-octave lattice cells and fractions: index 0 period 4, 1 period 8, 2 period 3
    typedef struct packed {
        logic [2:0]  x0, x1, y0, y1;
        logic [15:0] fx, fy;
    } axis_t;

    logic [31:0] seed_reg;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_we)
            seed_reg <= cfg_wdata;
    end

    // stall chain: a stage moves when downstream moves or it is empty
    always_comb
    begin
        adv[NST-1] = !out_stall || !vld_reg[NST-1];
        for (int i = NST-2; i >= 0; i--)
            adv[i] = adv[i+1] || !vld_reg[i];
    end
    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    function automatic logic [3:0] period_of(input int k);
        return (k == 0) ? 4'd4 : ((k == 1) ? 4'd8 : 4'd3);
    endfunction

    function automatic logic [31:0] seed_of(input int k, input logic [31:0] s);
        return (k == 0) ? s : ((k == 1) ? (s ^ SEED_XOR_P8) : (s ^ SEED_XOR_P3));
    endfunction

    // split one coordinate: cell wrapped to period, q0.16 fraction
    // period 3 wraps by a reciprocal multiply, exact for cells below 2048
    function automatic void split(input logic [7:0] c, input logic [3:0] p,
                                  output logic [2:0] c0, output logic [2:0] c1,
                                  output logic [15:0] f);
        logic [11:0] t;
        logic [11:0] cell_idx;
        logic [11:0] rem;
        logic [3:0]  m0;
        logic [3:0]  m1;
        logic [27:0] fw;
        t        = 12'(p) * 12'(c);
        cell_idx = 12'(t >> SHIFT);
        rem      = t & 12'(MAP_SIZE - 1);
        m0       = (p == 4'd3)
                 ? 4'(cell_idx - 12'd3 * 12'((24'(cell_idx) * 24'd1366) >> 12))
                 : 4'(cell_idx & 12'(p - 4'd1));
        m1       = (m0 + 4'd1 == p) ? 4'd0 : m0 + 4'd1;
        fw       = 28'(rem) << 16;
        f        = 16'(fw >> SHIFT);
        c0       = m0[2:0];
        c1       = m1[2:0];
    endfunction

    // cells and fractions of the incoming word
    axis_t ax0_next [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            split(in_data.texel_x, period_of(k), ax0_next[k].x0, ax0_next[k].x1,
                  ax0_next[k].fx);
            split(in_data.texel_y, period_of(k), ax0_next[k].y0, ax0_next[k].y1,
                  ax0_next[k].fy);
        end
    end

    // stage 0: cells and fractions
    axis_t ax0_reg [3];
    logic [31:0] sd0_reg;
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sd0_reg <= seed_reg;
            ax0_reg <= ax0_next;
        end
    end

    // stage 1: smoothstep squares and first hash mix
    logic [15:0] f2x1_reg [3], f2y1_reg [3], fx1_reg [3], fy1_reg [3];
    logic [31:0] hpre1_reg [3][4];
    always_ff @(posedge clk)
    begin
        if (adv[1])
            for (int k = 0; k < 3; k++)
            begin
                f2x1_reg[k] <= 16'((32'(ax0_reg[k].fx) * 32'(ax0_reg[k].fx)) >> 16);
                f2y1_reg[k] <= 16'((32'(ax0_reg[k].fy) * 32'(ax0_reg[k].fy)) >> 16);
                fx1_reg[k]  <= ax0_reg[k].fx;
                fy1_reg[k]  <= ax0_reg[k].fy;
                for (int j = 0; j < 4; j++)
                    hpre1_reg[k][j] <= seed_of(k, sd0_reg)
                        ^ (32'(j[0] ? ax0_reg[k].x1 : ax0_reg[k].x0) * HASH_MUL_X)
                        ^ (32'(j[1] ? ax0_reg[k].y1 : ax0_reg[k].y0) * HASH_MUL_Y);
            end
    end

    // stage 2: smoothstep weights and hash multiply
    logic [15:0] sx2_reg [3], sy2_reg [3];
    logic [31:0] hm2_reg [3][4];
    always_ff @(posedge clk)
    begin
        if (adv[2])
            for (int k = 0; k < 3; k++)
            begin
                sx2_reg[k] <= 16'((34'(f2x1_reg[k]) *
                               (34'(196608) - 34'({fx1_reg[k], 1'b0}))) >> 16);
                sy2_reg[k] <= 16'((34'(f2y1_reg[k]) *
                               (34'(196608) - 34'({fy1_reg[k], 1'b0}))) >> 16);
                for (int j = 0; j < 4; j++)
                    hm2_reg[k][j] <= (hpre1_reg[k][j] ^ (hpre1_reg[k][j] >> 13))
                                     * HASH_MUL_MIX;
            end
    end

    function automatic logic [23:0] mix(input logic [23:0] a, input logic [23:0] b,
                                        input logic [15:0] s);
        logic [40:0] acc;
        acc = 41'(a) * (41'(17'h10000) - 41'(s)) + 41'(b) * 41'(s);
        return 24'(acc >> 16);
    endfunction

    // stage 3: finish hash and first blend along x
    logic [23:0] bx3_reg [3][2];
    logic [15:0] sy3_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv[3])
            for (int k = 0; k < 3; k++)
            begin
                sy3_reg[k] <= sy2_reg[k];
                for (int r = 0; r < 2; r++)
                    bx3_reg[k][r] <= mix(
                        24'(hm2_reg[k][2*r]   ^ (hm2_reg[k][2*r]   >> 16)),
                        24'(hm2_reg[k][2*r+1] ^ (hm2_reg[k][2*r+1] >> 16)),
                        sx2_reg[k]);
            end
    end

    // stage 4: blend along y
    logic [23:0] n4_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv[4])
            for (int k = 0; k < 3; k++)
                n4_reg[k] <= mix(bx3_reg[k][0], bx3_reg[k][1], sy3_reg[k]);
    end

    // stage 5: octave weighting
    logic [23:0] cov5_reg, typ5_reg;
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            cov5_reg <= 24'((41'(n4_reg[0]) * 41'(WEIGHT_P4) +
                             41'(n4_reg[1]) * 41'(WEIGHT_P8)) >> 16);
            typ5_reg <= n4_reg[2];
        end
    end

    // stage 6: byte conversion
    texel_out_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            out_reg.coverage_byte <= 8'((32'(cov5_reg) * 32'd255 + 32'h800000) >> 24);
            out_reg.type_byte     <= 8'((32'(typ5_reg) * 32'd255 + 32'h800000) >> 24);
        end
    end
    assign out_data = out_reg;

endmodule
